/* hw/rtl/iou_track_table_assert.svh */
// Assertion macros for the track table RTL.
`ifndef IOU_TRACK_TABLE_ASSERT_SVH
`define IOU_TRACK_TABLE_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define IOU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define IOU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/iou_tt_pkg.sv */
package iou_tt_pkg;

    localparam int MAX_TRACKS_DEF = 16;
    localparam int COORD_BITS_DEF = 12;
    localparam int FIELD_BITS     = 12;
    localparam int CFG_AW         = 3;

    // Result kinds
    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_TRACK = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // Register indexes (address bit 2)
    localparam logic [0:0] REG_MATCH_TENTHS = 1'b0;
    localparam logic [0:0] REG_LIFE_RESET   = 1'b1;

    localparam logic [3:0] MATCH_TENTHS_RST = 4'd4;
    localparam logic [7:0] LIFE_RESET_RST   = 8'd5;

    typedef struct packed {
        logic                  mode;
        logic [FIELD_BITS-1:0] det_x;
        logic [FIELD_BITS-1:0] det_y;
        logic [FIELD_BITS-1:0] det_w;
        logic [FIELD_BITS-1:0] det_h;
    } in_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [31:0]           track_id;
        logic                  matched;
        logic                  dropped;
        logic [FIELD_BITS-1:0] trk_x;
        logic [FIELD_BITS-1:0] trk_y;
        logic [FIELD_BITS-1:0] trk_w;
        logic [FIELD_BITS-1:0] trk_h;
        logic [7:0]            life_left;
        logic                  last;
    } out_t;

    // Overlap unit result
    typedef struct packed {
        logic valid;
        logic hit;
    } iou_res_t;

endpackage

/* hw/rtl/iou_tt_ram.sv */
module iou_tt_ram
    import iou_tt_pkg::*;
#(
    parameter int DEPTH = MAX_TRACKS_DEF,
    parameter int WIDTH = 4 * COORD_BITS_DEF + 40,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/iou_tt_iou.sv */
module iou_tt_iou
    import iou_tt_pkg::*;
#(
    parameter int C  = COORD_BITS_DEF,
    parameter int TW = 44
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [4*C-1:0] det_rect,
    input  logic [3:0]     tenths,
    input  logic           in_v,
    input  logic [TW-1:0]  in_tag,
    input  logic [4*C-1:0] slot_rect,
    output iou_res_t       res,
    output logic [TW-1:0]  out_tag,
    output logic           busy
);

    localparam int PW = 2 * C + 2;
    localparam int LW = 2 * C + 6;

    logic [C-1:0] ax, ay, aw, ah, bx, by, bw, bh;
    logic [C:0]   ax2, ay2, bx2, by2, x1, y1, x2, y2, iw, ih;
    logic [PW-1:0] uni;
    logic [LW-1:0] lhs, rhs;

    logic          va_reg, vb_reg, vc_reg, hit_reg;
    logic [TW-1:0] tag_a_reg, tag_b_reg, tag_c_reg;
    logic [C:0]    iw_reg, ih_reg;
    logic [C-1:0]  bw_reg, bh_reg;
    logic [2*C-1:0] area_a_reg, area_b_reg;
    logic [PW-1:0] inter_reg;

    assign {ax, ay, aw, ah} = det_rect;
    assign {bx, by, bw, bh} = slot_rect;

    // Intersection extent
    always_comb begin
        ax2 = {1'b0, ax} + {1'b0, aw};
        ay2 = {1'b0, ay} + {1'b0, ah};
        bx2 = {1'b0, bx} + {1'b0, bw};
        by2 = {1'b0, by} + {1'b0, bh};
        x1  = (ax > bx) ? {1'b0, ax} : {1'b0, bx};
        y1  = (ay > by) ? {1'b0, ay} : {1'b0, by};
        x2  = (ax2 < bx2) ? ax2 : bx2;
        y2  = (ay2 < by2) ? ay2 : by2;
        iw  = (x2 > x1) ? x2 - x1 : '0;
        ih  = (y2 > y1) ? y2 - y1 : '0;
    end

    // Union and exact ratio test: inter*10 > tenths*union
    always_comb begin
        uni = PW'(area_a_reg) + PW'(area_b_reg) - inter_reg;
        lhs = (LW'(inter_reg) << 3) + (LW'(inter_reg) << 1);
        rhs = LW'(uni) * LW'(tenths);
    end

    // Valid flags of the three stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            va_reg <= in_v;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    // Payload of the three stages
    always_ff @(posedge aclk) begin
        area_a_reg <= aw * ah;
        tag_a_reg  <= in_tag;
        iw_reg     <= iw;
        ih_reg     <= ih;
        bw_reg     <= bw;
        bh_reg     <= bh;
        tag_b_reg  <= tag_a_reg;
        inter_reg  <= iw_reg * ih_reg;
        area_b_reg <= bw_reg * bh_reg;
        tag_c_reg  <= tag_b_reg;
        hit_reg    <= lhs > rhs;
    end

    assign res.valid = vc_reg;
    assign res.hit   = hit_reg;
    assign out_tag   = tag_c_reg;
    assign busy      = va_reg | vb_reg | vc_reg;

endmodule

/* hw/rtl/iou_track_table.sv */
// Track table: detections are matched against the live tracks by an exact
// intersection-over-union test and either update the first matching track
// (lowest id), open a new one or, with the table full, are dropped; an
// end-of-frame item ages all tracks and reports the survivors in ascending
// id order. Track state lives in a one-port-read, one-port-write RAM of
// MAX_TRACKS entries; every operation is a sweep over that RAM, one entry
// read per cycle. A detection gives its result after the sweep, the
// three-stage overlap unit and the write-back, and the next item is
// accepted from the cycle in which that result is presented. An end of
// frame sweeps the RAM once for aging (the empty report, if any, comes at
// its end) and once more per reported track, since each report is a
// minimum-id search over the RAM; a stalled result channel holds each
// report back. One item is processed at a time; a new item is accepted
// while the previous result still waits in the output register.
`include "iou_track_table_assert.svh"

module iou_track_table
    import iou_tt_pkg::*;
#(
    parameter int MAX_TRACKS = MAX_TRACKS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IW = $clog2(MAX_TRACKS);
    localparam int CW = IW + 1;
    localparam int C  = COORD_BITS;
    localparam int RW = 4 * C;
    localparam int EW = RW + 40;
    localparam int TW = IW + 40;
    localparam logic [CW-1:0] NSLOT = CW'(MAX_TRACKS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DET_DONE,
        ST_AGE,
        ST_AGE_DONE,
        ST_SEL,
        ST_EMIT_TRK
    } state_t;

    state_t state_reg, state_next;
    logic [RW-1:0] det_rect_reg, det_rect_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic rd_v_reg, rd_v_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic [MAX_TRACKS-1:0] valid_reg, valid_next, found_reg, found_next;
    logic [31:0] next_id_reg, next_id_next;
    logic [3:0] tenths_reg, tenths_next;
    logic [7:0] life_rst_reg, life_rst_next;
    logic best_v_reg, best_v_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic [31:0] best_id_reg, best_id_next;
    logic [7:0] best_life_reg, best_life_next;
    logic [CW-1:0] live_reg, live_next, sent_reg, sent_next;
    logic last_v_reg, last_v_next;
    logic [IW-1:0] last_idx_reg, last_idx_next;
    logic [31:0] last_id_reg, last_id_next;
    logic cand_v_reg, cand_v_next;
    logic [IW-1:0] cand_idx_reg, cand_idx_next;
    logic [31:0] cand_id_reg, cand_id_next;
    logic [7:0] cand_life_reg, cand_life_next;
    logic [RW-1:0] cand_rect_reg, cand_rect_next;
    logic m_valid_reg, m_valid_next;
    out_t m_data_reg, m_data_next;

    logic rd_en, wr_en;
    logic [IW-1:0] wr_addr;
    logic [EW-1:0] rd_data, wr_data;
    logic [RW-1:0] rd_rect;
    logic [31:0] rd_id;
    logic [7:0] rd_life, aged_life;
    logic issue, out_free, free_v, iou_busy, cfg_wr, after_last;
    logic [IW-1:0] free_idx, t_idx;
    logic [31:0] t_id;
    logic [7:0] t_life;
    logic [TW-1:0] iou_tag_out;
    iou_res_t iou_res;

    assign {rd_rect, rd_id, rd_life} = rd_data;
    assign {t_idx, t_id, t_life} = iou_tag_out;

    // Lowest free slot
    always_comb begin
        free_v   = 1'b0;
        free_idx = '0;
        for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_v   = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    iou_tt_ram #(.DEPTH(MAX_TRACKS), .WIDTH(EW)) u_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[IW-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    iou_tt_iou #(.C(C), .TW(TW)) u_iou (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .det_rect  (det_rect_reg),
        .tenths    (tenths_reg),
        .in_v      (state_reg == ST_SCAN && rd_v_reg && valid_reg[rd_idx_reg]),
        .in_tag    ({rd_idx_reg, rd_id, rd_life}),
        .slot_rect (rd_rect),
        .res       (iou_res),
        .out_tag   (iou_tag_out),
        .busy      (iou_busy)
    );

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb begin
        case (paddr[2])
            REG_MATCH_TENTHS: prdata = {28'd0, tenths_reg};
            REG_LIFE_RESET:   prdata = {24'd0, life_rst_reg};
            default:          prdata = '0;
        endcase
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign issue    = (cnt_reg != NSLOT) &&
                      (state_reg == ST_SCAN || state_reg == ST_AGE || state_reg == ST_SEL);
    assign rd_en    = issue;
    assign aged_life = found_reg[rd_idx_reg] ? life_rst_reg :
                       (rd_life == 8'd0) ? 8'd0 : rd_life - 8'd1;
    assign after_last = !last_v_reg || rd_id > last_id_reg ||
                        (rd_id == last_id_reg && rd_idx_reg > last_idx_reg);

    // Next-state logic
    always_comb begin
        state_next     = state_reg;
        det_rect_next  = det_rect_reg;
        cnt_next       = issue ? cnt_reg + CW'(1) : cnt_reg;
        rd_v_next      = issue;
        rd_idx_next    = cnt_reg[IW-1:0];
        valid_next     = valid_reg;
        found_next     = found_reg;
        next_id_next   = next_id_reg;
        tenths_next    = tenths_reg;
        life_rst_next  = life_rst_reg;
        best_v_next    = best_v_reg;
        best_idx_next  = best_idx_reg;
        best_id_next   = best_id_reg;
        best_life_next = best_life_reg;
        live_next      = live_reg;
        sent_next      = sent_reg;
        last_v_next    = last_v_reg;
        last_idx_next  = last_idx_reg;
        last_id_next   = last_id_reg;
        cand_v_next    = cand_v_reg;
        cand_idx_next  = cand_idx_reg;
        cand_id_next   = cand_id_reg;
        cand_life_next = cand_life_reg;
        cand_rect_next = cand_rect_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        wr_en          = 1'b0;
        wr_addr        = rd_idx_reg;
        wr_data        = {rd_rect, rd_id, aged_life};

        // Register writes
        if (cfg_wr) begin
            case (paddr[2])
                REG_MATCH_TENTHS: tenths_next = pwdata[3:0];
                REG_LIFE_RESET:   life_rst_next = pwdata[7:0];
                default:          tenths_next = tenths_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_valid) begin
                    det_rect_next = {C'(s_data.det_x), C'(s_data.det_y),
                                     C'(s_data.det_w), C'(s_data.det_h)};
                    best_v_next   = 1'b0;
                    live_next     = '0;
                    state_next    = s_data.mode ? ST_AGE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Keep the lowest-id hit; ties keep the lower slot
                if (iou_res.valid && iou_res.hit && (!best_v_reg || t_id < best_id_reg)) begin
                    best_v_next    = 1'b1;
                    best_idx_next  = t_idx;
                    best_id_next   = t_id;
                    best_life_next = t_life;
                end
                if (!issue && !rd_v_reg && !iou_busy) begin
                    state_next = ST_DET_DONE;
                end
            end
            ST_DET_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next.kind = KIND_ACK;
                    m_data_next.last = 1'b1;
                    m_data_next.trk_x = FIELD_BITS'(det_rect_reg[4*C-1:3*C]);
                    m_data_next.trk_y = FIELD_BITS'(det_rect_reg[3*C-1:2*C]);
                    m_data_next.trk_w = FIELD_BITS'(det_rect_reg[2*C-1:C]);
                    m_data_next.trk_h = FIELD_BITS'(det_rect_reg[C-1:0]);
                    if (best_v_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = best_idx_reg;
                        wr_data = {det_rect_reg, best_id_reg, best_life_reg};
                        found_next[best_idx_reg] = 1'b1;
                        m_data_next.matched   = 1'b1;
                        m_data_next.track_id  = best_id_reg;
                        m_data_next.life_left = best_life_reg;
                    end else if (free_v) begin
                        wr_en   = 1'b1;
                        wr_addr = free_idx;
                        wr_data = {det_rect_reg, next_id_reg, life_rst_reg};
                        valid_next[free_idx] = 1'b1;
                        found_next[free_idx] = 1'b0;
                        next_id_next = next_id_reg + 32'd1;
                        m_data_next.track_id  = next_id_reg;
                        m_data_next.life_left = life_rst_reg;
                    end else begin
                        m_data_next.dropped = 1'b1;
                        m_data_next.trk_x = '0;
                        m_data_next.trk_y = '0;
                        m_data_next.trk_w = '0;
                        m_data_next.trk_h = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_AGE: begin
                // Refresh found tracks, age the rest, free those at zero
                if (rd_v_reg && valid_reg[rd_idx_reg]) begin
                    wr_en = 1'b1;
                    found_next[rd_idx_reg] = 1'b0;
                    if (aged_life == 8'd0) begin
                        valid_next[rd_idx_reg] = 1'b0;
                    end else begin
                        live_next = live_reg + CW'(1);
                    end
                end
                if (!issue && !rd_v_reg) begin
                    state_next = ST_AGE_DONE;
                end
            end
            ST_AGE_DONE: begin
                sent_next   = '0;
                last_v_next = 1'b0;
                cand_v_next = 1'b0;
                cnt_next    = '0;
                if (live_reg != '0) begin
                    state_next = ST_SEL;
                end else if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_data_next      = '0;
                    m_data_next.kind = KIND_EMPTY;
                    m_data_next.last = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_SEL: begin
                // Smallest (id, slot) beyond the last reported one
                if (rd_v_reg && valid_reg[rd_idx_reg] && after_last &&
                    (!cand_v_reg || rd_id < cand_id_reg)) begin
                    cand_v_next    = 1'b1;
                    cand_idx_next  = rd_idx_reg;
                    cand_id_next   = rd_id;
                    cand_life_next = rd_life;
                    cand_rect_next = rd_rect;
                end
                if (!issue && !rd_v_reg) begin
                    state_next = ST_EMIT_TRK;
                end
            end
            ST_EMIT_TRK: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next.kind      = KIND_TRACK;
                    m_data_next.track_id  = cand_id_reg;
                    m_data_next.trk_x     = FIELD_BITS'(cand_rect_reg[4*C-1:3*C]);
                    m_data_next.trk_y     = FIELD_BITS'(cand_rect_reg[3*C-1:2*C]);
                    m_data_next.trk_w     = FIELD_BITS'(cand_rect_reg[2*C-1:C]);
                    m_data_next.trk_h     = FIELD_BITS'(cand_rect_reg[C-1:0]);
                    m_data_next.life_left = cand_life_reg;
                    m_data_next.last      = (sent_reg + CW'(1) == live_reg);
                    sent_next     = sent_reg + CW'(1);
                    last_v_next   = 1'b1;
                    last_id_next  = cand_id_reg;
                    last_idx_next = cand_idx_reg;
                    cand_v_next   = 1'b0;
                    cnt_next      = '0;
                    state_next    = (sent_reg + CW'(1) == live_reg) ? ST_IDLE : ST_SEL;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            rd_v_reg     <= 1'b0;
            valid_reg    <= '0;
            found_reg    <= '0;
            next_id_reg  <= '0;
            tenths_reg   <= MATCH_TENTHS_RST;
            life_rst_reg <= LIFE_RESET_RST;
            best_v_reg   <= 1'b0;
            live_reg     <= '0;
            sent_reg     <= '0;
            last_v_reg   <= 1'b0;
            cand_v_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_v_reg     <= rd_v_next;
            valid_reg    <= valid_next;
            found_reg    <= found_next;
            next_id_reg  <= next_id_next;
            tenths_reg   <= tenths_next;
            life_rst_reg <= life_rst_next;
            best_v_reg   <= best_v_next;
            live_reg     <= live_next;
            sent_reg     <= sent_next;
            last_v_reg   <= last_v_next;
            cand_v_reg   <= cand_v_next;
            m_valid_reg  <= m_valid_next;
        end
        det_rect_reg  <= det_rect_next;
        rd_idx_reg    <= rd_idx_next;
        best_idx_reg  <= best_idx_next;
        best_id_reg   <= best_id_next;
        best_life_reg <= best_life_next;
        last_idx_reg  <= last_idx_next;
        last_id_reg   <= last_id_next;
        cand_idx_reg  <= cand_idx_next;
        cand_id_reg   <= cand_id_next;
        cand_life_reg <= cand_life_next;
        cand_rect_reg <= cand_rect_next;
        m_data_reg    <= m_data_next;
    end

    `IOU_ASSERT_IMP(a_found_live, 1'b1, (found_reg & ~valid_reg) == '0,
                    "found mark set on a free slot")
    `IOU_ASSERT_IMP(a_idle_quiet, s_ready, !iou_busy && !rd_v_reg,
                    "table sweep still running while idle")
    `IOU_ASSERT_IMP(a_sel_order, state_reg == ST_SEL && cand_v_reg && last_v_reg,
                    cand_id_reg >= last_id_reg, "track report out of id order")

endmodule
